### rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and bit functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] hash_t;

    // Control of the block buffer / schedule window
    typedef struct packed {
        logic push;   // shift one byte in
        logic shift;  // advance the schedule by one word
    } sched_ctrl_t;

    // Control of the round unit
    typedef struct packed {
        logic load;    // copy the hash words into the working variables
        logic step;    // run one round
        logic update;  // fold the working variables into the hash words
        logic init;    // restore the initial hash words
    } round_ctrl_t;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned LEN_POS     = 56;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;

    // Initial hash words, element 0 is the most significant digest word
    localparam hash_t HASH_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

### rtl/shs_sched.sv
// ----------------------------------------------------------------------------
// shs_sched
// Block buffer and message schedule: bytes shift in to fill a 512-bit block,
// which then serves as the sliding 16-word window of the schedule.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_sched (
    input  wire logic                clk,
    input  wire shs_pkg::sched_ctrl_t ctrl,
    input  wire logic [7:0]          byte_in,
    output shs_pkg::word_t           w_out
);
    import shs_pkg::*;

    // Word i of the window sits at bits [511-32i -: 32]
    logic [511:0] win_reg;
    logic [511:0] win_next;
    word_t        w_new;

    assign w_out = win_reg[511:480];

    // W[t+16] from W[t], W[t+1], W[t+9] and W[t+14]
    assign w_new = small_sigma1(win_reg[63:32]) + win_reg[223:192]
                 + small_sigma0(win_reg[479:448]) + win_reg[511:480];

    always_comb
    begin
        win_next = win_reg;
        if (ctrl.push)
        begin
            win_next = {win_reg[503:0], byte_in};
        end
        else if (ctrl.shift)
        begin
            win_next = {win_reg[479:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

`default_nettype wire

### rtl/shs_round.sv
// ----------------------------------------------------------------------------
// shs_round
// Compression round unit: working variables a..h, one round per step, and
// the eight chaining hash words.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_round (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire shs_pkg::round_ctrl_t ctrl,
    input  wire shs_pkg::word_t      k_in,
    input  wire shs_pkg::word_t      w_in,
    output shs_pkg::hash_t           hash
);
    import shs_pkg::*;

    hash_t hash_reg;
    hash_t hash_next;
    hash_t v_reg;
    hash_t v_next;
    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;

    assign hash = hash_reg;

    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + big_sigma1(v_reg[4]) + ch + k_in + w_in;
    assign t2  = big_sigma0(v_reg[0]) + maj;

    always_comb
    begin
        v_next = v_reg;
        if (ctrl.load)
        begin
            v_next = hash_reg;
        end
        else if (ctrl.step)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
    end

    always_comb
    begin
        hash_next = hash_reg;
        if (ctrl.init)
        begin
            hash_next = HASH_INIT;
        end
        else if (ctrl.update)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = hash_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= HASH_INIT;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule

`default_nettype wire

### rtl/sha256_stream_hasher.sv
// Byte input: one transaction per cycle while idle; the 64th byte of a block
// starts a compression (64 rounds, one hash update), input held.
// End of message: padding bytes one per cycle up to the block end, one or two
// compressions, then eight digest transactions, one per cycle when taken.
// Reset (rst_n, asynchronous): initial hash words, empty block, zero length.
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-serial SHA-256 with padding and digest output, built around one
// round unit stepped by a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] has_byte
    input  wire logic        s_axis_tlast,   // end_of_message
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic             m_axis_tlast    // last_word
);
    import shs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_COMP = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [5:0] LAST_FILL  = 6'(BLOCK_BYTES - 1);
    localparam logic [5:0] LEN_FILL   = 6'(LEN_POS);
    localparam logic [5:0] LAST_ROUND = 6'd63;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] msg_reg, msg_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  word_reg, word_next;
    logic        pend_reg, pend_next;      // more padding after this compression
    logic        final_reg, final_next;    // this compression ends the message
    logic        first_reg, first_next;    // next pad byte is the 0x80 marker
    logic        zrest_reg, zrest_next;    // marker fell into the length field

    sched_ctrl_t sctrl;
    round_ctrl_t rctrl;
    logic [7:0]  push_byte;
    word_t       w_t;
    hash_t       hash;
    logic [63:0] len_shift;
    logic        len_phase;
    logic        in_fire;
    logic        out_fire;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {5'b0, word_reg, hash[word_reg]};
    assign m_axis_tlast  = (word_reg == 3'd7);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    // Length bytes go out big-endian at block positions 56..63
    assign len_shift = {msg_reg, 3'b000} >> {3'd7 - fill_reg[2:0], 3'b000};
    assign len_phase = !first_reg && !zrest_reg && (fill_reg >= LEN_FILL);

    shs_sched u_sched (
        .clk     (clk),
        .ctrl    (sctrl),
        .byte_in (push_byte),
        .w_out   (w_t)
    );

    shs_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rctrl),
        .k_in  (ROUND_K[round_reg]),
        .w_in  (w_t),
        .hash  (hash)
    );

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        msg_next   = msg_reg;
        round_next = round_reg;
        word_next  = word_reg;
        pend_next  = pend_reg;
        final_next = final_reg;
        first_next = first_reg;
        zrest_next = zrest_reg;
        sctrl      = '0;
        rctrl      = '0;
        push_byte  = s_axis_tdata;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser)
                    begin
                        sctrl.push = 1'b1;
                        fill_next  = fill_reg + 6'd1;
                        msg_next   = msg_reg + 61'd1;
                    end
                    if (s_axis_tuser && (fill_reg == LAST_FILL))
                    begin
                        rctrl.load = 1'b1;
                        round_next = '0;
                        final_next = 1'b0;
                        pend_next  = s_axis_tlast;
                        first_next = 1'b1;
                        zrest_next = 1'b0;
                        state_next = S_COMP;
                    end
                    else if (s_axis_tlast)
                    begin
                        first_next = 1'b1;
                        zrest_next = 1'b0;
                        state_next = S_PAD;
                    end
                end
            end

            S_PAD:
            begin
                sctrl.push = 1'b1;
                if (first_reg)
                begin
                    push_byte = PAD_BYTE;
                end
                else if (len_phase)
                begin
                    push_byte = len_shift[7:0];
                end
                else
                begin
                    push_byte = 8'h00;
                end
                fill_next  = fill_reg + 6'd1;
                first_next = 1'b0;
                if (first_reg && (fill_reg >= LEN_FILL))
                begin
                    zrest_next = 1'b1;
                end
                if (fill_reg == LAST_FILL)
                begin
                    rctrl.load = 1'b1;
                    round_next = '0;
                    final_next = len_phase;
                    pend_next  = 1'b1;
                    zrest_next = 1'b0;
                    state_next = S_COMP;
                end
            end

            S_COMP:
            begin
                rctrl.step  = 1'b1;
                sctrl.shift = 1'b1;
                round_next  = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = S_UPD;
                end
            end

            S_UPD:
            begin
                rctrl.update = 1'b1;
                if (final_reg)
                begin
                    word_next  = '0;
                    state_next = S_OUT;
                end
                else if (pend_reg)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_OUT:
            begin
                if (out_fire)
                begin
                    word_next = word_reg + 3'd1;
                    if (word_reg == 3'd7)
                    begin
                        rctrl.init = 1'b1;
                        msg_next   = '0;
                        fill_next  = '0;
                        final_next = 1'b0;
                        pend_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            msg_reg   <= '0;
            round_reg <= '0;
            word_reg  <= '0;
            pend_reg  <= 1'b0;
            final_reg <= 1'b0;
            first_reg <= 1'b0;
            zrest_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            msg_reg   <= msg_next;
            round_reg <= round_next;
            word_reg  <= word_next;
            pend_reg  <= pend_next;
            final_reg <= final_next;
            first_reg <= first_next;
            zrest_reg <= zrest_next;
        end
    end

endmodule

`default_nettype wire
